// ----- hw/rtl/sorted_key_value_table_core_assert.svh -----
// Assertion macros used by the sorted key-value table core.
`ifndef SORTED_KEY_VALUE_TABLE_CORE_ASSERT_SVH
`define SORTED_KEY_VALUE_TABLE_CORE_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define SKVT_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("sorted key-value table: invariant violated");

// A condition that must hold in the cycle after the antecedent.
`define SKVT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted key-value table: sequence violated");

`endif

// ----- hw/rtl/skvt_pkg.sv -----
// Shared types, codes and defaults for the sorted key-value table.
package skvt_pkg;

  localparam int CAPACITY_DEF   = 32;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  localparam logic [1:0] ACTION_INSERT = 2'd0;
  localparam logic [1:0] ACTION_FIND   = 2'd1;
  localparam logic [1:0] ACTION_REMOVE = 2'd2;
  localparam logic [1:0] ACTION_RANGE  = 2'd3;

  localparam logic [2:0] STATUS_INSERTED    = 3'd0;
  localparam logic [2:0] STATUS_UPDATED     = 3'd1;
  localparam logic [2:0] STATUS_FOUND       = 3'd2;
  localparam logic [2:0] STATUS_NOT_FOUND   = 3'd3;
  localparam logic [2:0] STATUS_REMOVED     = 3'd4;
  localparam logic [2:0] STATUS_FULL        = 3'd5;
  localparam logic [2:0] STATUS_RANGE_ITEM  = 3'd6;
  localparam logic [2:0] STATUS_RANGE_EMPTY = 3'd7;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] key;
    logic signed [31:0] key_high;
    logic [31:0]        value;
  } skvt_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] out_key;
    logic [31:0]        out_value;
    logic [5:0]         entry_count;
    logic               last;
  } skvt_rsp_t;

  // Commands broadcast to every cell of the chain.
  typedef struct packed {
    logic eval;
    logic ins;
    logic rem;
    logic upd;
    logic tok_load;
    logic tok_shift;
  } skvt_cmd_t;

  // Status a cell shows to its neighbors and to the controller.
  typedef struct packed {
    logic valid;
    logic lt;
    logic eq;
    logic inr;
    logic tok;
  } skvt_flag_t;

  localparam skvt_flag_t FLAG_LEFT_EDGE = '{valid: 1'b0, lt: 1'b1, eq: 1'b0,
                                            inr: 1'b0, tok: 1'b0};
  localparam skvt_flag_t FLAG_RIGHT_EDGE = '{valid: 1'b0, lt: 1'b0, eq: 1'b0,
                                             inr: 1'b0, tok: 1'b0};

endpackage

// ----- hw/rtl/skvt_cell.sv -----
// One storage cell of the sorted chain: holds an entry and shifts with its neighbors.
module skvt_cell #(
  parameter int KEY_BITS   = skvt_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = skvt_pkg::VALUE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  skvt_pkg::skvt_cmd_t    cmd,
  input  logic [KEY_BITS-1:0]    cmd_key,
  input  logic [KEY_BITS-1:0]    cmd_key_high,
  input  logic [VALUE_BITS-1:0]  cmd_value,
  input  skvt_pkg::skvt_flag_t   left_flag,
  input  logic [KEY_BITS-1:0]    left_key,
  input  logic [VALUE_BITS-1:0]  left_value,
  input  skvt_pkg::skvt_flag_t   right_flag,
  input  logic [KEY_BITS-1:0]    right_key,
  input  logic [VALUE_BITS-1:0]  right_value,
  output skvt_pkg::skvt_flag_t   flag,
  output logic [KEY_BITS-1:0]    cell_key,
  output logic [VALUE_BITS-1:0]  cell_value
);

  logic below_low;
  logic above_high;
  logic at_pos;

  assign below_low  = $signed(cell_key) < $signed(cmd_key);
  assign above_high = $signed(cmd_key_high) < $signed(cell_key);
  assign at_pos     = !flag.lt && left_flag.lt;

  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= skvt_pkg::FLAG_RIGHT_EDGE;
    end else begin
      if (cmd.eval) begin
        flag.lt  <= flag.valid && below_low;
        flag.eq  <= flag.valid && (cell_key == cmd_key);
        flag.inr <= flag.valid && !below_low && !above_high;
      end
      if (cmd.ins && !flag.lt) begin
        flag.valid <= at_pos ? 1'b1 : left_flag.valid;
      end else if (cmd.rem && !flag.lt) begin
        flag.valid <= right_flag.valid;
      end
      if (cmd.tok_load) begin
        flag.tok <= at_pos;
      end else if (cmd.tok_shift) begin
        flag.tok <= left_flag.tok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins && !flag.lt) begin
      if (at_pos) begin
        cell_key   <= cmd_key;
        cell_value <= cmd_value;
      end else begin
        cell_key   <= left_key;
        cell_value <= left_value;
      end
    end else if (cmd.rem && !flag.lt) begin
      cell_key   <= right_key;
      cell_value <= right_value;
    end else if (cmd.upd && flag.eq) begin
      cell_value <= cmd_value;
    end
  end

endmodule

// ----- hw/rtl/sorted_key_value_table_core.sv -----
// Top level of the sorted key-value table: request control, cell chain and result register.
//
// Requests arrive on req with req_valid/req_stall; results leave on rsp with
// rsp_valid/rsp_stall. Each request inserts or updates, finds, removes, or asks
// for every entry whose key lies in [key, key_high]. Entries sit in a chain of
// CAPACITY cells kept in ascending signed key order; all cells compare the
// request key in parallel and shift by one place on insert or remove.
// Insert, update, find and remove each give one result, loaded into the result
// register in the apply state; the next request can be taken in that state
// while rsp is not stalled. A range query gives one result per entry in range,
// ordered by key, the final one with last set; an empty range gives one
// range-empty result. Throughput is set by the compare cycle and the apply cycle
// of the chain, and for ranges by the single result register. Every result
// carries the entry count after the request.
// Reset is synchronous; it empties the table and drops any request in flight.
// While rsp is stalled the result register holds its item. The block can
// still take one request while idle and compare it, but it holds an insert,
// find or remove in the apply state without applying it and takes no further
// request until the pending result can move.
`include "sorted_key_value_table_core_assert.svh"

module sorted_key_value_table_core #(
  parameter int CAPACITY   = skvt_pkg::CAPACITY_DEF,
  parameter int KEY_BITS   = skvt_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = skvt_pkg::VALUE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  skvt_pkg::skvt_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output skvt_pkg::skvt_rsp_t rsp
);

  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EVAL  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;
  localparam logic [1:0] S_RANGE = 2'd3;

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [CW-1:0]         occ;
  logic [CW-1:0]         occ_next;
  logic [1:0]            act;
  logic [KEY_BITS-1:0]   rk;
  logic [KEY_BITS-1:0]   rkh;
  logic [VALUE_BITS-1:0] rv;

  skvt_pkg::skvt_cmd_t   cmd;
  skvt_pkg::skvt_flag_t  cell_flag  [CAPACITY];
  logic [KEY_BITS-1:0]   cell_key   [CAPACITY];
  logic [VALUE_BITS-1:0] cell_value [CAPACITY];

  logic [CAPACITY-1:0]   valid_vec;
  logic [CAPACITY-1:0]   eq_vec;
  logic [CAPACITY-1:0]   tok_vec;
  logic [CAPACITY-1:0]   sel_vec;
  logic [CAPACITY-1:0]   last_vec;
  logic [KEY_BITS-1:0]   sel_key;
  logic [VALUE_BITS-1:0] sel_value;

  logic                  hit;
  logic                  full;
  logic                  any_sel;
  logic                  out_free;
  logic                  accept;
  logic                  emit;
  logic [2:0]            emit_status;
  logic                  emit_data;
  logic                  emit_last;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      skvt_pkg::skvt_flag_t  lf;
      skvt_pkg::skvt_flag_t  rf;
      logic [KEY_BITS-1:0]   lk;
      logic [KEY_BITS-1:0]   rkey;
      logic [VALUE_BITS-1:0] lv;
      logic [VALUE_BITS-1:0] rval;

      if (gi == 0) begin : g_left_edge
        assign lf = skvt_pkg::FLAG_LEFT_EDGE;
        assign lk = '0;
        assign lv = '0;
      end else begin : g_left
        assign lf = cell_flag[gi-1];
        assign lk = cell_key[gi-1];
        assign lv = cell_value[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_right_edge
        assign rf   = skvt_pkg::FLAG_RIGHT_EDGE;
        assign rkey = '0;
        assign rval = '0;
      end else begin : g_right
        assign rf   = cell_flag[gi+1];
        assign rkey = cell_key[gi+1];
        assign rval = cell_value[gi+1];
      end

      skvt_cell #(
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
      ) u_cell (
        .clk          (clk),
        .rst          (rst),
        .cmd          (cmd),
        .cmd_key      (rk),
        .cmd_key_high (rkh),
        .cmd_value    (rv),
        .left_flag    (lf),
        .left_key     (lk),
        .left_value   (lv),
        .right_flag   (rf),
        .right_key    (rkey),
        .right_value  (rval),
        .flag         (cell_flag[gi]),
        .cell_key     (cell_key[gi]),
        .cell_value   (cell_value[gi])
      );

      assign valid_vec[gi] = cell_flag[gi].valid;
      assign eq_vec[gi]    = cell_flag[gi].eq;
      assign tok_vec[gi]   = cell_flag[gi].tok;
      assign last_vec[gi]  = cell_flag[gi].tok && cell_flag[gi].inr && !rf.inr;
    end
  endgenerate

  always_comb begin
    sel_vec   = (state == S_APPLY) ? eq_vec : '0;
    sel_key   = '0;
    sel_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (state == S_RANGE) begin
        sel_vec[i] = cell_flag[i].tok && cell_flag[i].inr;
      end
      sel_key   = sel_key | ({KEY_BITS{sel_vec[i]}} & cell_key[i]);
      sel_value = sel_value | ({VALUE_BITS{sel_vec[i]}} & cell_value[i]);
    end
  end

  assign hit      = |eq_vec;
  assign any_sel  = |sel_vec;
  assign full     = occ == CW'(CAPACITY);
  assign out_free = !rsp_valid || !rsp_stall;

  assign req_stall = !((state == S_IDLE) ||
                       (state == S_APPLY && act != skvt_pkg::ACTION_RANGE && out_free));
  assign accept    = req_valid && !req_stall;

  always_comb begin
    state_next  = state;
    occ_next    = occ;
    cmd         = '0;
    emit        = 1'b0;
    emit_status = skvt_pkg::STATUS_NOT_FOUND;
    emit_data   = 1'b0;
    emit_last   = 1'b1;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = S_APPLY;
      end
      S_APPLY: begin
        if (act == skvt_pkg::ACTION_RANGE) begin
          cmd.tok_load = 1'b1;
          state_next   = S_RANGE;
        end else if (out_free) begin
          emit       = 1'b1;
          state_next = accept ? S_EVAL : S_IDLE;
          case (act)
            skvt_pkg::ACTION_INSERT: begin
              if (hit) begin
                cmd.upd     = 1'b1;
                emit_status = skvt_pkg::STATUS_UPDATED;
              end else if (full) begin
                emit_status = skvt_pkg::STATUS_FULL;
              end else begin
                cmd.ins     = 1'b1;
                occ_next    = occ + CW'(1);
                emit_status = skvt_pkg::STATUS_INSERTED;
              end
            end
            skvt_pkg::ACTION_FIND: begin
              if (hit) begin
                emit_status = skvt_pkg::STATUS_FOUND;
                emit_data   = 1'b1;
              end
            end
            skvt_pkg::ACTION_REMOVE: begin
              if (hit) begin
                cmd.rem     = 1'b1;
                occ_next    = occ - CW'(1);
                emit_status = skvt_pkg::STATUS_REMOVED;
              end
            end
            default: begin
              emit = 1'b0;
            end
          endcase
        end
      end
      S_RANGE: begin
        if (out_free) begin
          emit = 1'b1;
          if (any_sel) begin
            emit_status   = skvt_pkg::STATUS_RANGE_ITEM;
            emit_data     = 1'b1;
            emit_last     = |last_vec;
            cmd.tok_shift = !emit_last;
            state_next    = emit_last ? S_IDLE : S_RANGE;
          end else begin
            emit_status = skvt_pkg::STATUS_RANGE_EMPTY;
            state_next  = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act <= req.action;
      rk  <= KEY_BITS'(req.key);
      rkh <= KEY_BITS'(req.key_high);
      rv  <= VALUE_BITS'(req.value);
    end
    if (emit) begin
      rsp.status      <= emit_status;
      rsp.out_key     <= emit_data ? 32'(sel_key) : '0;
      rsp.out_value   <= emit_data ? 32'(sel_value) : '0;
      rsp.entry_count <= 6'(occ_next);
      rsp.last        <= emit_last;
    end
  end

  `SKVT_ASSERT_ALWAYS(a_occ_bound, occ <= CW'(CAPACITY))
  `SKVT_ASSERT_ALWAYS(a_occ_matches_cells, $countones(valid_vec) == int'(occ))
  `SKVT_ASSERT_ALWAYS(a_single_match, (state != S_APPLY) || $onehot0(eq_vec))
  `SKVT_ASSERT_ALWAYS(a_single_token, $onehot0(tok_vec))
  `SKVT_ASSERT_NEXT(a_range_ends, state == S_RANGE && emit && emit_last, state != S_RANGE)

endmodule
